>>> rtl/bmd_pkg.sv
// Package for the block mean downsampler: shared types and constants.
`default_nettype none

package bmd_pkg;

  localparam int SUM_W      = 24;    // column sum and mean width
  localparam int FRAC_W     = 8;     // fraction bits of the mean
  localparam int DIVD_W     = SUM_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DIVD_W);
  localparam int COORD_W    = 12;    // row and column counters
  localparam int CFG_W      = 13;    // widest register
  localparam int FACTOR_W   = 5;     // factor register
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd2;
  localparam logic [CFG_W-1:0]    WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0]    HEIGHT_RESET = 13'd480;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_LOAD
  } bmd_state_t;

  typedef struct packed {
    logic accept;
    logic calc;
    logic div_start;
    logic load;
  } bmd_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_busy;
  } bmd_stat_t;

endpackage

`default_nettype wire

>>> rtl/block_mean_downsampler_core.sv
// Top level of the block mean downsampler.
`default_nettype none

// Reduces a raster image to factor-by-factor block means in unsigned Q16.8,
// keeping one partial sum per output column in an on-chip memory. A pixel
// is captured, then its column sum goes through a read-modify-write; a
// pixel that closes a block in the last row of its band then waits for the
// bit-serial divider and for the load of the output register, which waits
// while the previous result is still stalled at the output.
// A register write restarts the frame; column sums need no clearing.
module block_mean_downsampler_core #(
  parameter int PIXEL_BITS = 16,
  parameter int MAX_FACTOR = 16,
  parameter int MAX_WIDTH  = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bmd_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [15:0]                   pixel,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bmd_pkg::SUM_W-1:0]          mean_value,
  output logic [bmd_pkg::COORD_W-1:0]        out_row,
  output logic [bmd_pkg::COORD_W-1:0]        out_col,
  output logic                               frame_end
);

  bmd_pkg::bmd_cmd_t  cmd;
  bmd_pkg::bmd_stat_t stat;

  bmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmd_datapath #(
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_FACTOR (MAX_FACTOR),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_value (mean_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_end  (frame_end)
  );

endmodule

`default_nettype wire

>>> rtl/bmd_ctrl.sv
// Controller state machine of the block mean downsampler.
`default_nettype none

module bmd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bmd_pkg::bmd_stat_t stat,
  output bmd_pkg::bmd_cmd_t      cmd
);

  bmd_pkg::bmd_state_t state;
  bmd_pkg::bmd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bmd_pkg::ST_IDLE: begin
        if (in_valid) state_next = bmd_pkg::ST_CALC;
      end
      bmd_pkg::ST_CALC: begin
        state_next = stat.emit ? bmd_pkg::ST_DIV : bmd_pkg::ST_IDLE;
      end
      bmd_pkg::ST_DIV: begin
        if (stat.div_done) state_next = bmd_pkg::ST_LOAD;
      end
      bmd_pkg::ST_LOAD: begin
        if (!stat.out_busy) state_next = bmd_pkg::ST_IDLE;
      end
      default: state_next = bmd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      bmd_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      bmd_pkg::ST_CALC: begin
        cmd.calc      = 1'b1;
        cmd.div_start = stat.emit;
      end
      bmd_pkg::ST_DIV: begin
      end
      bmd_pkg::ST_LOAD: begin
        cmd.load = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/bmd_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module bmd_divider #(
  parameter int CNT_W = 9
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bmd_pkg::DIVD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]           divisor,
  output logic [bmd_pkg::DIVD_W-1:0]      quotient,
  output logic                            done
);

  logic                           busy;
  logic [bmd_pkg::DIV_CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]               rem;
  logic [CNT_W-1:0]               dvs;
  logic [CNT_W:0]                 shifted;
  logic [CNT_W:0]                 diff;
  logic                           fits;

  assign shifted = {rem, quotient[bmd_pkg::DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};
  assign done    = busy && (cnt == bmd_pkg::DIV_CNT_W'(bmd_pkg::DIVD_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quotient <= {quotient[bmd_pkg::DIVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> rtl/bmd_datapath.sv
// Datapath: config registers, position counters, column sum memory, divider, output register.
`default_nettype none

module bmd_datapath #(
  parameter int PIXEL_BITS = 16,
  parameter int MAX_FACTOR = 16,
  parameter int MAX_WIDTH  = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [bmd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bmd_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic [15:0]                          pixel,
  input  wire bmd_pkg::bmd_cmd_t                    cmd,
  output bmd_pkg::bmd_stat_t                        stat,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [bmd_pkg::SUM_W-1:0]                 mean_value,
  output logic [bmd_pkg::COORD_W-1:0]               out_row,
  output logic [bmd_pkg::COORD_W-1:0]               out_col,
  output logic                                      frame_end
);

  localparam int FACT_W = $clog2(MAX_FACTOR);
  localparam int RUN_W  = PIXEL_BITS + FACT_W;
  localparam int CNT_W  = 2 * FACT_W + 1;
  localparam int ADDR_W = $clog2(MAX_WIDTH);

  logic [bmd_pkg::FACTOR_W-1:0] factor;
  logic [bmd_pkg::CFG_W-1:0]    source_width;
  logic [bmd_pkg::CFG_W-1:0]    source_height;

  logic [bmd_pkg::FACTOR_W-1:0] f_cl;
  logic [bmd_pkg::CFG_W-1:0]    w_cl;
  logic [bmd_pkg::CFG_W-1:0]    h_cl;
  logic [FACT_W-1:0]            f_m1;
  logic [bmd_pkg::CFG_W-1:0]    w_m1;
  logic [bmd_pkg::CFG_W-1:0]    h_m1;

  logic [PIXEL_BITS-1:0]        pix;
  logic [RUN_W-1:0]             run_sum;
  logic [bmd_pkg::COORD_W-1:0]  src_row;
  logic [bmd_pkg::COORD_W-1:0]  src_col;
  logic [FACT_W-1:0]            row_in_band;
  logic [FACT_W-1:0]            col_in_block;
  logic [bmd_pkg::COORD_W-1:0]  block_col;
  logic [bmd_pkg::COORD_W-1:0]  band_row;

  logic [bmd_pkg::SUM_W-1:0]    column_sums [MAX_WIDTH];
  logic [bmd_pkg::SUM_W-1:0]    rd_data;
  logic [ADDR_W-1:0]            idx;

  logic                         row_end;
  logic                         last_row;
  logic                         block_end;
  logic                         band_end;
  logic [RUN_W-1:0]             sum;
  logic [bmd_pkg::SUM_W-1:0]    acc;
  logic [FACT_W:0]              rows_n;
  logic [FACT_W:0]              cols_n;
  logic [2*FACT_W+1:0]          prod;
  logic [CNT_W-1:0]             count;
  logic                         cfg_hit;

  logic [bmd_pkg::COORD_W-1:0]  pend_row;
  logic [bmd_pkg::COORD_W-1:0]  pend_col;
  logic                         pend_fe;
  logic [bmd_pkg::DIVD_W-1:0]   quotient;
  logic                         div_done;

  always_comb begin
    if (factor == '0) f_cl = bmd_pkg::FACTOR_W'(1);
    else if (factor > bmd_pkg::FACTOR_W'(MAX_FACTOR)) f_cl = bmd_pkg::FACTOR_W'(MAX_FACTOR);
    else f_cl = factor;
    if (source_width == '0) w_cl = bmd_pkg::CFG_W'(1);
    else if (source_width > bmd_pkg::CFG_W'(MAX_WIDTH)) w_cl = bmd_pkg::CFG_W'(MAX_WIDTH);
    else w_cl = source_width;
    if (source_height == '0) h_cl = bmd_pkg::CFG_W'(1);
    else if (source_height > bmd_pkg::CFG_W'(bmd_pkg::MAX_HEIGHT)) begin
      h_cl = bmd_pkg::CFG_W'(bmd_pkg::MAX_HEIGHT);
    end else h_cl = source_height;
  end

  assign f_m1 = FACT_W'(f_cl - bmd_pkg::FACTOR_W'(1));
  assign w_m1 = w_cl - bmd_pkg::CFG_W'(1);
  assign h_m1 = h_cl - bmd_pkg::CFG_W'(1);

  assign row_end   = {1'b0, src_col} >= w_m1;
  assign last_row  = {1'b0, src_row} >= h_m1;
  assign block_end = row_end || (col_in_block >= f_m1);
  assign band_end  = last_row || (row_in_band >= f_m1);

  assign sum    = run_sum + RUN_W'(pix);
  assign acc    = ((row_in_band == '0) ? '0 : rd_data) + bmd_pkg::SUM_W'(sum);
  assign rows_n = {1'b0, row_in_band} + 1'b1;
  assign cols_n = {1'b0, col_in_block} + 1'b1;
  assign prod   = rows_n * cols_n;
  assign count  = prod[CNT_W-1:0];
  assign idx    = block_col[ADDR_W-1:0];

  assign cfg_hit = cfg_we && ((cfg_index == bmd_pkg::REG_FACTOR) ||
                              (cfg_index == bmd_pkg::REG_SOURCE_WIDTH) ||
                              (cfg_index == bmd_pkg::REG_SOURCE_HEIGHT));

  assign stat.emit     = block_end && band_end;
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor        <= bmd_pkg::FACTOR_RESET;
      source_width  <= bmd_pkg::WIDTH_RESET;
      source_height <= bmd_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmd_pkg::REG_FACTOR:        factor        <= cfg_data[bmd_pkg::FACTOR_W-1:0];
        bmd_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        bmd_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // position counters; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      run_sum      <= '0;
      src_row      <= '0;
      src_col      <= '0;
      row_in_band  <= '0;
      col_in_block <= '0;
      block_col    <= '0;
      band_row     <= '0;
    end else if (cmd.calc) begin
      if (block_end) begin
        run_sum      <= '0;
        col_in_block <= '0;
        block_col    <= block_col + 1'b1;
      end else begin
        run_sum      <= sum;
        col_in_block <= col_in_block + 1'b1;
      end
      if (row_end) begin
        src_col      <= '0;
        block_col    <= '0;
        col_in_block <= '0;
        if (last_row) begin
          src_row     <= '0;
          row_in_band <= '0;
          band_row    <= '0;
        end else begin
          src_row <= src_row + 1'b1;
          if (band_end) begin
            row_in_band <= '0;
            band_row    <= band_row + 1'b1;
          end else begin
            row_in_band <= row_in_band + 1'b1;
          end
        end
      end else begin
        src_col <= src_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc && block_end) column_sums[idx] <= acc;
    rd_data <= column_sums[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) pix <= pixel[PIXEL_BITS-1:0];
    if (cmd.calc && stat.emit) begin
      pend_row <= band_row;
      pend_col <= block_col;
      pend_fe  <= row_end && last_row;
    end
  end

  bmd_divider #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({acc, bmd_pkg::FRAC_W'(0)}),
    .divisor  (count),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mean_value <= quotient[bmd_pkg::SUM_W-1:0];
      out_row    <= pend_row;
      out_col    <= pend_col;
      frame_end  <= pend_fe;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bmd_checker.sv
// Port-level checks for the block mean downsampler, bound to the top level.
`default_nettype none

module bmd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [bmd_pkg::SUM_W-1:0]     mean_value,
  input wire logic [bmd_pkg::COORD_W-1:0]   out_row,
  input wire logic [bmd_pkg::COORD_W-1:0]   out_col,
  input wire logic                          frame_end
);

  // a transfer in blocks the input for at least the next cycle
  a_in_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after transfer");

  // a new result is loaded only while the input side is busy
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(mean_value) && $stable(out_row) &&
       $stable(out_col) && $stable(frame_end)))
    else $error("stalled result changed");

  a_out_drop_on_transfer: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without transfer");

endmodule

bind block_mean_downsampler_core bmd_checker u_bmd_checker (.*);

`default_nettype wire
